// ----- rtl/core/slpc_pkg.sv -----
`default_nettype none

package slpc_pkg;

    // Default build of the block.
    localparam int NUM_BUTTONS_DEF = 4;
    localparam int COUNT_BITS_DEF  = 16;

    // Fixed field widths of the channels.
    localparam int PIN_COUNT   = 4;
    localparam int OPCODE_W    = 2;
    localparam int PINS_W      = 4;
    localparam int IDX_W       = 2;
    localparam int STATE_W     = 2;
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 64;
    localparam int BUTTONS_W   = 3;

    // Reset values of the configuration registers.
    localparam logic [CFG_DATA_W-1:0] SHORT_THR_RESET = 64'h0001_0001_0001_0001;
    localparam logic [CFG_DATA_W-1:0] LONG_THR_RESET  = 64'h0001_0001_0001_0001;
    localparam logic [BUTTONS_W-1:0]  BUTTONS_RESET   = 3'd4;
    localparam logic                  POLARITY_RESET  = 1'b0;

    typedef enum logic [STATE_W-1:0] {
        ST_RELEASED = 2'd0,
        ST_SHORT    = 2'd1,
        ST_LONG     = 2'd2,
        ST_FAULT    = 2'd3
    } press_t;

    typedef enum logic [OPCODE_W-1:0] {
        OP_TICK         = 2'd0,
        OP_READ_LEVEL   = 2'd1,
        OP_READ_EDGE    = 2'd2,
        OP_READ_RELEASE = 2'd3
    } opcode_t;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_SHORT_THR = 2'd0,
        CFG_LONG_THR  = 2'd1,
        CFG_BUTTONS   = 2'd2,
        CFG_POLARITY  = 2'd3
    } cfg_index_t;

    // Command from the top level to one button lane.
    typedef struct packed {
        logic    tick_en;
        logic    pressed;
        logic    query_en;
        opcode_t op;
    } lane_cmd_t;

endpackage

`default_nettype wire

// ----- rtl/core/slpc_if.sv -----
`default_nettype none

// Item channel: one tick or one query per transaction.
interface slpc_in_if import slpc_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [OPCODE_W-1:0] opcode;
    logic [PINS_W-1:0]   pin_levels;
    logic [IDX_W-1:0]    button_index;

    modport source (output valid, output opcode, output pin_levels,
                    output button_index, input ready);
    modport sink   (input valid, input opcode, input pin_levels,
                    input button_index, output ready);
endinterface

// Result channel: one press state per transaction.
interface slpc_out_if import slpc_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [STATE_W-1:0] press_state;

    modport source (output valid, output press_state, input ready);
    modport sink   (input valid, input press_state, output ready);
endinterface

// Configuration write channel.
interface slpc_cfg_if import slpc_pkg::*; ();
    logic                   valid;
    logic                   ready;
    logic [CFG_INDEX_W-1:0] index;
    logic [CFG_DATA_W-1:0]  data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ----- rtl/core/slpc_lane.sv -----
`default_nettype none

// Next-state logic of one button: press machine, hold counter and latches.
module slpc_lane import slpc_pkg::*; #(
    parameter int COUNT_BITS = COUNT_BITS_DEF
) (
    input  lane_cmd_t             cmd,
    input  logic [COUNT_BITS-1:0] short_thr,
    input  logic [COUNT_BITS-1:0] long_thr,
    input  press_t                level,
    input  logic [COUNT_BITS:0]   count,
    input  press_t                edge_latch,
    input  press_t                release_latch,
    output press_t                level_next,
    output logic [COUNT_BITS:0]   count_next,
    output press_t                edge_latch_next,
    output press_t                release_latch_next,
    output press_t                read_value
);

    localparam logic [COUNT_BITS:0] COUNT_MAX = '1;

    logic [COUNT_BITS-1:0] short_eff;
    logic [COUNT_BITS-1:0] long_eff;
    logic [COUNT_BITS:0]   count_inc;

    // A zero short threshold acts as one; long never lies below short.
    assign short_eff = (short_thr == '0) ? COUNT_BITS'(1) : short_thr;
    assign long_eff  = (long_thr < short_eff) ? short_eff : long_thr;
    assign count_inc = (count == COUNT_MAX) ? count : count + 1'b1;

    always_comb
    begin
        level_next         = level;
        count_next         = count;
        edge_latch_next    = edge_latch;
        release_latch_next = release_latch;
        read_value         = ST_RELEASED;

        if (cmd.tick_en)
        begin
            unique case (level)
                ST_RELEASED:
                begin
                    if (cmd.pressed)
                    begin
                        count_next = count_inc;
                        if (count_inc >= {1'b0, short_eff})
                        begin
                            level_next = ST_SHORT;
                        end
                    end
                    else
                    begin
                        count_next = '0;
                    end
                end
                ST_SHORT:
                begin
                    if (cmd.pressed)
                    begin
                        count_next = count_inc;
                        if (count_inc >= {1'b0, long_eff})
                        begin
                            level_next      = ST_LONG;
                            edge_latch_next = ST_LONG;
                            count_next      = '0;
                        end
                    end
                    else
                    begin
                        level_next         = ST_RELEASED;
                        count_next         = '0;
                        release_latch_next = ST_SHORT;
                        edge_latch_next    = ST_SHORT;
                    end
                end
                ST_LONG:
                begin
                    if (!cmd.pressed)
                    begin
                        level_next         = ST_RELEASED;
                        count_next         = '0;
                        release_latch_next = ST_LONG;
                    end
                end
                ST_FAULT:
                begin
                end
            endcase
        end

        if (cmd.query_en)
        begin
            unique case (cmd.op)
                OP_READ_LEVEL:
                begin
                    read_value      = level;
                    edge_latch_next = ST_RELEASED;
                end
                OP_READ_EDGE:
                begin
                    read_value      = edge_latch;
                    edge_latch_next = ST_RELEASED;
                end
                OP_READ_RELEASE:
                begin
                    read_value         = release_latch;
                    edge_latch_next    = ST_RELEASED;
                    release_latch_next = ST_RELEASED;
                end
                OP_TICK:
                begin
                end
            endcase
        end
    end

endmodule

`default_nettype wire

// ----- rtl/core/short_long_press_classifier.sv -----
`default_nettype none

// Channel      Modport  Transaction carries
// item_in      sink     opcode, pin_levels, button_index (tick or query)
// result_out   source   press_state (one per query, none per tick)
// cfg          sink     index, data (register write, always ready)
//
// One item is accepted per clock cycle, ticks and queries alike, unless a
// query is held by a stalled result; the rate is set by the single
// read-modify-write pass over the state row. A query is registered in the
// update stage with the state-memory read, then in the output register.
// Reset clears the row valid bit; an unwritten row reads as all buttons
// released with zero counts, so no clearing pass is needed.
// A stalled result stops the update stage only when it holds a query; ticks
// pass through it regardless.
module short_long_press_classifier import slpc_pkg::*; #(
    parameter int NUM_BUTTONS = NUM_BUTTONS_DEF,
    parameter int COUNT_BITS  = COUNT_BITS_DEF
) (
    input  wire        clk,
    input  wire        rst_n,
    slpc_in_if.sink    item_in,
    slpc_out_if.source result_out,
    slpc_cfg_if.sink   cfg
);

    // Each button occupies one lane of the state row:
    // {level, hold count, edge latch, release latch}.
    localparam int CW         = COUNT_BITS + 1;
    localparam int LANE_W     = 3 * STATE_W + CW;
    localparam int ROW_W      = NUM_BUTTONS * LANE_W;
    localparam int STATE_ROWS = 1;

    // Configuration registers.
    logic [CFG_DATA_W-1:0] short_thr_reg;
    logic [CFG_DATA_W-1:0] long_thr_reg;
    logic [BUTTONS_W-1:0]  buttons_reg;
    logic                  polarity_reg;

    // Update stage.
    logic                  s1_valid_reg;
    opcode_t               s1_op_reg;
    logic [PINS_W-1:0]     s1_pins_reg;
    logic [IDX_W-1:0]      s1_idx_reg;

    // Output register.
    logic                  out_valid_reg;
    press_t                out_state_reg;

    // State memory and its read/forward path.
    logic [ROW_W-1:0]      state_mem [STATE_ROWS];
    logic [ROW_W-1:0]      rd_row_reg;
    logic                  rd_valid_reg;
    logic                  row_valid_reg;
    logic                  fwd_hit_reg;
    logic [ROW_W-1:0]      fwd_row_reg;
    logic [ROW_W-1:0]      cur_row;
    logic [ROW_W-1:0]      wb_row;

    logic                  accept;
    logic                  s1_is_query;
    logic                  out_free;
    logic                  s1_fire;
    logic                  query_fault;
    logic [STATE_W-1:0]    read_or;
    press_t                result_state;

    press_t                lane_read [NUM_BUTTONS];

    // ------------------------------------------------------------------
    // Configuration port. Users must issue writes only while idle; not enforced.
    // ------------------------------------------------------------------
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            short_thr_reg <= SHORT_THR_RESET;
            long_thr_reg  <= LONG_THR_RESET;
            buttons_reg   <= BUTTONS_RESET;
            polarity_reg  <= POLARITY_RESET;
        end
        else if (cfg.valid)
        begin
            unique case (cfg_index_t'(cfg.index))
                CFG_SHORT_THR: short_thr_reg <= cfg.data;
                CFG_LONG_THR:  long_thr_reg  <= cfg.data;
                CFG_BUTTONS:   buttons_reg   <= cfg.data[BUTTONS_W-1:0];
                CFG_POLARITY:  polarity_reg  <= cfg.data[0];
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Handshake. The update stage moves on unless it holds a query whose
    // result has nowhere to go.
    // ------------------------------------------------------------------
    assign s1_is_query   = (s1_op_reg != OP_TICK);
    assign out_free      = !out_valid_reg || result_out.ready;
    assign s1_fire       = s1_valid_reg && (!s1_is_query || out_free);
    assign item_in.ready = !s1_valid_reg || s1_fire;
    assign accept        = item_in.valid && item_in.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            row_valid_reg <= 1'b0;
            rd_valid_reg  <= 1'b0;
            fwd_hit_reg   <= 1'b0;
        end
        else
        begin
            if (item_in.ready)
            begin
                s1_valid_reg <= item_in.valid;
            end

            if (s1_fire && s1_is_query)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (result_out.ready)
            begin
                out_valid_reg <= 1'b0;
            end

            if (s1_fire)
            begin
                row_valid_reg <= 1'b1;
            end

            // A read issued in the same cycle as a write-back sees the old
            // row, so the written row is forwarded instead.
            if (accept)
            begin
                rd_valid_reg <= row_valid_reg;
                fwd_hit_reg  <= s1_fire;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_op_reg   <= opcode_t'(item_in.opcode);
            s1_pins_reg <= item_in.pin_levels;
            s1_idx_reg  <= item_in.button_index;
        end
        if (s1_fire && s1_is_query)
        begin
            out_state_reg <= result_state;
        end
    end

    // ------------------------------------------------------------------
    // State memory: one row, synchronous read, write-back from the update
    // stage.
    // ------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        if (s1_fire)
        begin
            state_mem[0] <= wb_row;
            fwd_row_reg  <= wb_row;
        end
        if (accept)
        begin
            rd_row_reg <= state_mem[0];
        end
    end

    always_comb
    begin
        if (fwd_hit_reg)
        begin
            cur_row = fwd_row_reg;
        end
        else if (rd_valid_reg)
        begin
            cur_row = rd_row_reg;
        end
        else
        begin
            cur_row = '0;
        end
    end

    // ------------------------------------------------------------------
    // Button lanes.
    // ------------------------------------------------------------------
    for (genvar b = 0; b < NUM_BUTTONS; b++)
    begin : g_lane
        localparam int BASE  = b * LANE_W;
        localparam int SHIFT = b * COUNT_BITS;

        logic [CFG_DATA_W-1:0] short_shifted;
        logic [CFG_DATA_W-1:0] long_shifted;
        logic                  pin;
        logic                  active;
        lane_cmd_t             cmd;
        press_t                level_next;
        logic [CW-1:0]         count_next;
        press_t                edge_next;
        press_t                rel_next;

        // A field that lies past the top of the register reads zero.
        assign short_shifted = short_thr_reg >> SHIFT;
        assign long_shifted  = long_thr_reg >> SHIFT;

        if (b < PIN_COUNT)
        begin : g_pin
            assign pin = s1_pins_reg[b];
        end
        else
        begin : g_no_pin
            assign pin = 1'b0;
        end

        assign active       = (32'(buttons_reg) > b);
        assign cmd.tick_en  = (s1_op_reg == OP_TICK) && active;
        assign cmd.pressed  = (pin == polarity_reg);
        assign cmd.query_en = s1_is_query && active && (32'(s1_idx_reg) == b);
        assign cmd.op       = s1_op_reg;

        slpc_lane #(
            .COUNT_BITS (COUNT_BITS)
        ) u_lane (
            .cmd                (cmd),
            .short_thr          (short_shifted[COUNT_BITS-1:0]),
            .long_thr           (long_shifted[COUNT_BITS-1:0]),
            .level              (press_t'(cur_row[BASE+LANE_W-1 -: STATE_W])),
            .count              (cur_row[BASE+2*STATE_W +: CW]),
            .edge_latch         (press_t'(cur_row[BASE+STATE_W +: STATE_W])),
            .release_latch      (press_t'(cur_row[BASE +: STATE_W])),
            .level_next         (level_next),
            .count_next         (count_next),
            .edge_latch_next    (edge_next),
            .release_latch_next (rel_next),
            .read_value         (lane_read[b])
        );

        assign wb_row[BASE +: LANE_W] = {level_next, count_next, edge_next, rel_next};
    end

    // Only the addressed lane returns a non-zero value, so an OR selects it.
    always_comb
    begin
        read_or = '0;
        for (int b = 0; b < NUM_BUTTONS; b++)
        begin
            read_or = read_or | lane_read[b];
        end
    end

    assign query_fault  = (32'(s1_idx_reg) >= 32'(buttons_reg)) ||
                          (32'(s1_idx_reg) >= NUM_BUTTONS);
    assign result_state = query_fault ? ST_FAULT : press_t'(read_or);

    assign result_out.valid       = out_valid_reg;
    assign result_out.press_state = out_state_reg;

    // ------------------------------------------------------------------
    // Assertions.
    // ------------------------------------------------------------------
    a_query_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        s1_fire && s1_is_query |=> out_valid_reg)
        else $error("query left the update stage without a result");

    a_tick_gives_none: assert property (@(posedge clk) disable iff (!rst_n)
        s1_fire && !s1_is_query && out_free |=> !out_valid_reg)
        else $error("tick produced a result");

    a_fault_reported: assert property (@(posedge clk) disable iff (!rst_n)
        s1_fire && s1_is_query && query_fault |=> out_state_reg == ST_FAULT)
        else $error("query of an unused button did not report fault");

    a_forward_after_write: assert property (@(posedge clk) disable iff (!rst_n)
        fwd_hit_reg |-> row_valid_reg)
        else $error("forwarded row without any write-back");

endmodule

`default_nettype wire

// ----- dv/short_long_press_classifier_tb.sv -----
`default_nettype none

// Self-checking bench for the short/long press classifier.
// Stimulus walks through directed press sequences, threshold and button-count
// corner settings, then random tick/query traffic under several idling mixes,
// and finally a long result hold-off that backs the block up into its input.
// Every accepted item goes through a local model of the button machines and
// every query pushes its expected press state; the checker compares results in
// order as they come out.
module short_long_press_classifier_tb;
    import slpc_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int NUM_BTN      = NUM_BUTTONS_DEF;
    localparam int CNT_W        = COUNT_BITS_DEF;
    localparam int HOLD_W       = CNT_W + 1;
    // Extra wait after the last result, so that trailing ticks have surely
    // left the pipeline.
    localparam int SETTLE_CYCLES = 8;
    // Upper bound on the run length; the watchdog fails a run that reaches it.
    localparam int CYCLE_LIMIT  = 200_000;

    logic clk;
    logic rst_n;

    slpc_in_if  item_if ();
    slpc_out_if result_if ();
    slpc_cfg_if cfg_if ();

    short_long_press_classifier DUT (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_in    (item_if),
        .result_out (result_if),
        .cfg        (cfg_if)
    );

    // Mirror of the configuration registers, kept in step with every write
    // that the block accepts.
    logic [CFG_DATA_W-1:0] short_thr_q;
    logic [CFG_DATA_W-1:0] long_thr_q;
    logic [BUTTONS_W-1:0]  buttons_q;
    logic                  polarity_q;

    // Per-button state of the local press model.
    press_t             btn_level[NUM_BTN];
    logic [HOLD_W-1:0]  btn_hold[NUM_BTN];
    press_t             btn_edge[NUM_BTN];
    press_t             btn_release[NUM_BTN];

    // Press states still owed by the block, oldest first.
    press_t expected_press[$];

    int mismatch_count = 0;
    int cycle_count    = 0;

    // Idling mix of the current phase, in percent of cycles.
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;

    // A request for the receiver to hold off for this many cycles. The
    // receiver process picks it up and counts it down on its own.
    int holdoff_request = 0;

    // ------------------------------------------------------------------
    // Clock, reset and watchdog.
    // ------------------------------------------------------------------
    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // The watchdog fails the run if it has not finished by the cycle limit.
    initial
    begin : watchdog
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("== FAIL ==");
        $finish;
    end

    // ------------------------------------------------------------------
    // Press model.
    // ------------------------------------------------------------------

    // Number of buttons taking part; a count above the build size is capped
    // and a count of zero leaves every button out.
    function automatic int unsigned active_buttons();
        return (buttons_q > NUM_BTN) ? NUM_BTN : buttons_q;
    endfunction

    // A threshold field that starts past the top of the register reads 0;
    // one that straddles the top keeps only the bits that exist.
    function automatic logic [HOLD_W-1:0] threshold_of(logic [CFG_DATA_W-1:0] reg_val,
                                                       int b);
        logic [CFG_DATA_W-1:0] shifted;
        if (b * CNT_W >= CFG_DATA_W)
            return '0;
        shifted = reg_val >> (b * CNT_W);
        return {1'b0, shifted[CNT_W-1:0]};
    endfunction

    // One tick of one button machine.
    function automatic void tick_button(int b, bit pressed);
        logic [HOLD_W-1:0] short_lim;
        logic [HOLD_W-1:0] long_lim;
        short_lim = threshold_of(short_thr_q, b);
        long_lim  = threshold_of(long_thr_q, b);
        // A zero short threshold acts as one, and the long threshold is
        // never allowed below the short one.
        if (short_lim == 0)
            short_lim = 1;
        if (long_lim < short_lim)
            long_lim = short_lim;

        case (btn_level[b])
            ST_RELEASED:
            begin
                if (pressed)
                begin
                    if (btn_hold[b] != '1)
                        btn_hold[b]++;
                    if (btn_hold[b] >= short_lim)
                        btn_level[b] = ST_SHORT;
                end
                else
                begin
                    btn_hold[b] = '0;
                end
            end
            ST_SHORT:
            begin
                if (pressed)
                begin
                    if (btn_hold[b] != '1)
                        btn_hold[b]++;
                    if (btn_hold[b] >= long_lim)
                    begin
                        btn_level[b] = ST_LONG;
                        btn_edge[b]  = ST_LONG;
                        btn_hold[b]  = '0;
                    end
                end
                else
                begin
                    btn_level[b]   = ST_RELEASED;
                    btn_hold[b]    = '0;
                    btn_release[b] = ST_SHORT;
                    btn_edge[b]    = ST_SHORT;
                end
            end
            ST_LONG:
            begin
                if (!pressed)
                begin
                    btn_level[b]   = ST_RELEASED;
                    btn_hold[b]    = '0;
                    btn_release[b] = ST_LONG;
                end
            end
            default:
            begin
            end
        endcase
    endfunction

    // Applies one accepted item to the model and queues the press state that
    // a query must return.
    function automatic void classify_item(opcode_t op, logic [PINS_W-1:0] pins,
                                          logic [IDX_W-1:0] idx);
        int unsigned n;
        press_t      answer;
        bit          pin_level;
        n = active_buttons();
        if (op == OP_TICK)
        begin
            // Buttons that are not in use keep their state frozen.
            for (int b = 0; b < n; b++)
            begin
                pin_level = (b < PINS_W) ? pins[b] : 1'b0;
                tick_button(b, pin_level == polarity_q);
            end
            return;
        end

        // A query of a button that is not in use reports fault and touches
        // nothing.
        if (idx >= n)
        begin
            expected_press.push_back(ST_FAULT);
            return;
        end

        case (op)
            OP_READ_LEVEL:
            begin
                answer = btn_level[idx];
                btn_edge[idx] = ST_RELEASED;
            end
            OP_READ_EDGE:
            begin
                answer = btn_edge[idx];
                btn_edge[idx] = ST_RELEASED;
            end
            default:
            begin
                answer = btn_release[idx];
                btn_edge[idx]    = ST_RELEASED;
                btn_release[idx] = ST_RELEASED;
            end
        endcase
        expected_press.push_back(answer);
    endfunction

    function automatic void apply_register(cfg_index_t idx, logic [CFG_DATA_W-1:0] data);
        case (idx)
            CFG_SHORT_THR: short_thr_q = data;
            CFG_LONG_THR:  long_thr_q  = data;
            CFG_BUTTONS:   buttons_q   = data[BUTTONS_W-1:0];
            CFG_POLARITY:  polarity_q  = data[0];
            default:
            begin
            end
        endcase
    endfunction

    function automatic void reset_model();
        short_thr_q = SHORT_THR_RESET;
        long_thr_q  = LONG_THR_RESET;
        buttons_q   = BUTTONS_RESET;
        polarity_q  = POLARITY_RESET;
        for (int b = 0; b < NUM_BTN; b++)
        begin
            btn_level[b]   = ST_RELEASED;
            btn_hold[b]    = '0;
            btn_edge[b]    = ST_RELEASED;
            btn_release[b] = ST_RELEASED;
        end
    endfunction

    // ------------------------------------------------------------------
    // Result side: ready generation and checking.
    // ------------------------------------------------------------------

    // Ready is redrawn every cycle from the stall mix of the phase, except
    // while a hold-off is being counted down, when it stays low throughout.
    initial
    begin : result_ready_gen
        int holdoff_left;
        holdoff_left = 0;
        result_if.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (holdoff_request > 0)
            begin
                holdoff_left    = holdoff_request;
                holdoff_request = 0;
            end
            if (holdoff_left > 0)
            begin
                holdoff_left--;
                result_if.ready <= 1'b0;
            end
            else
            begin
                result_if.ready <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    task automatic report_mismatch(string what);
        $display("ERROR at cycle %0d: %s", cycle_count, what);
        mismatch_count++;
    endtask

    // Each result transaction is matched against the oldest expectation.
    always @(posedge clk)
    begin : check_result
        press_t want;
        if (rst_n && result_if.valid && result_if.ready)
        begin
            if (expected_press.size() == 0)
            begin
                report_mismatch($sformatf("result %0d with no query outstanding",
                                          result_if.press_state));
            end
            else
            begin
                want = expected_press.pop_front();
                if (result_if.press_state !== want)
                    report_mismatch($sformatf("press_state %0d, expected %0d",
                                              result_if.press_state, want));
            end
        end
    end

    // ------------------------------------------------------------------
    // Item and configuration drivers.
    // ------------------------------------------------------------------

    // Offers one item and returns at the edge that accepts it. Valid is left
    // high so that a follow-on item can be offered in the very next cycle;
    // an idle cycle of the next call, or the drain, lowers it.
    task automatic send_item(opcode_t op, logic [PINS_W-1:0] pins,
                             logic [IDX_W-1:0] idx);
        while ($urandom_range(99) < send_idle_pct)
        begin
            item_if.valid <= 1'b0;
            @(posedge clk);
        end
        item_if.valid        <= 1'b1;
        item_if.opcode       <= op;
        item_if.pin_levels   <= pins;
        item_if.button_index <= idx;
        do
            @(posedge clk);
        while (!item_if.ready);
        classify_item(op, pins, idx);
    endtask

    // A query carries random pin bits, which the block must ignore.
    task automatic send_query(opcode_t op, logic [IDX_W-1:0] idx);
        send_item(op, PINS_W'($urandom), idx);
    endtask

    // The button index of a tick is random and must be ignored.
    task automatic send_tick(logic [PINS_W-1:0] pins);
        send_item(OP_TICK, pins, IDX_W'($urandom));
    endtask

    // Stops offering items and waits until every query has been answered
    // and trailing ticks have left the pipeline.
    task automatic drain_results();
        item_if.valid <= 1'b0;
        @(posedge clk);
        while (expected_press.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Register writes are only issued after drain_results, with the block idle.
    task automatic write_register(cfg_index_t idx, logic [CFG_DATA_W-1:0] data);
        cfg_if.valid <= 1'b1;
        cfg_if.index <= idx;
        cfg_if.data  <= data;
        do
            @(posedge clk);
        while (!cfg_if.ready);
        apply_register(idx, data);
        cfg_if.valid <= 1'b0;
        @(posedge clk);
    endtask

    // Small random thresholds keep presses reaching short and long within a
    // handful of ticks. Zero thresholds and long below short come up often,
    // so the clamping is exercised throughout. The unused upper bits of the
    // count and polarity writes carry random junk.
    task automatic randomize_settings();
        logic [CFG_DATA_W-1:0] short_val;
        logic [CFG_DATA_W-1:0] long_val;
        logic [CFG_DATA_W-1:0] junk;
        short_val = '0;
        long_val  = '0;
        for (int b = 0; b < NUM_BTN; b++)
        begin
            short_val[b*CNT_W +: CNT_W] = CNT_W'($urandom_range(0, 5));
            long_val[b*CNT_W +: CNT_W]  = CNT_W'($urandom_range(0, 9));
        end
        junk = {$urandom, $urandom};
        write_register(CFG_SHORT_THR, short_val);
        write_register(CFG_LONG_THR, long_val);
        if ($urandom_range(99) < 70)
            junk[BUTTONS_W-1:0] = BUTTONS_W'(NUM_BTN);
        else
            junk[BUTTONS_W-1:0] = BUTTONS_W'($urandom_range(0, 7));
        write_register(CFG_BUTTONS, junk);
        write_register(CFG_POLARITY, {$urandom, $urandom});
    endtask

    // ------------------------------------------------------------------
    // Tests.
    // ------------------------------------------------------------------

    // Reset settings: every threshold is one and a low pin counts as pressed.
    // Walks a short press, a long press and both latches through their reads.
    task automatic test_press_sequences();
        send_query(OP_READ_LEVEL, 2'd0);
        send_query(OP_READ_EDGE, 2'd3);
        send_query(OP_READ_RELEASE, 2'd2);
        // Button 0 alone pressed reaches short press after one tick.
        send_tick(4'b1110);
        send_query(OP_READ_LEVEL, 2'd0);
        // Release from short sets both latches to short.
        send_tick(4'b1111);
        send_query(OP_READ_EDGE, 2'd0);
        send_query(OP_READ_RELEASE, 2'd0);
        // Two pressed ticks carry every button through to long press.
        send_tick(4'b0000);
        send_tick(4'b0000);
        send_query(OP_READ_EDGE, 2'd1);
        send_query(OP_READ_LEVEL, 2'd2);
        send_tick(4'b1111);
        // The release latch reads long once and is clear afterwards.
        send_query(OP_READ_RELEASE, 2'd3);
        send_query(OP_READ_RELEASE, 2'd3);
        send_query(OP_READ_EDGE, 2'd0);
        drain_results();
    endtask

    // No buttons in use, a count past the build size, and a partial count.
    task automatic test_button_count_limits();
        write_register(CFG_BUTTONS, '0);
        send_tick(4'b0000);
        send_query(OP_READ_LEVEL, 2'd0);
        drain_results();
        write_register(CFG_BUTTONS, CFG_DATA_W'(7));
        send_query(OP_READ_LEVEL, 2'd3);
        drain_results();
        write_register(CFG_BUTTONS, CFG_DATA_W'(2));
        send_tick(4'b0000);
        send_query(OP_READ_EDGE, 2'd2);
        drain_results();
        write_register(CFG_BUTTONS, CFG_DATA_W'(NUM_BTN));
    endtask

    // Largest thresholds hold the buttons released; zero thresholds then
    // behave as one, so the counts built up fire at once.
    task automatic test_threshold_extremes();
        write_register(CFG_SHORT_THR, '1);
        write_register(CFG_LONG_THR, '1);
        write_register(CFG_POLARITY, CFG_DATA_W'(1));
        send_tick(4'b1111);
        send_tick(4'b0101);
        send_query(OP_READ_LEVEL, 2'd0);
        drain_results();
        write_register(CFG_SHORT_THR, '0);
        write_register(CFG_LONG_THR, '0);
        send_tick(4'b1111);
        send_tick(4'b1111);
        send_query(OP_READ_EDGE, 2'd1);
        drain_results();
    endtask

    // Random traffic shaped like real button activity: runs of ticks with a
    // held pin pattern, so presses last long enough to reach short and long,
    // mixed with queries. Now and then the whole pattern jumps at random.
    task automatic test_random_traffic(int idle_pct, int stall_pct, int item_total);
        logic [PINS_W-1:0] pins;
        int                sent;
        drain_results();
        randomize_settings();
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        pins = PINS_W'($urandom);
        sent = 0;
        while (sent < item_total)
        begin
            if ($urandom_range(99) < 15)
                pins = PINS_W'($urandom);
            else if ($urandom_range(99) < 50)
                pins[$urandom_range(PINS_W - 1)] ^= 1'b1;
            repeat ($urandom_range(1, 6))
            begin
                send_tick(pins);
                sent++;
            end
            repeat ($urandom_range(0, 3))
            begin
                send_query(opcode_t'($urandom_range(1, 3)), IDX_W'($urandom));
                sent++;
            end
        end
        drain_results();
    endtask

    // The receiver holds off for a long stretch while queries keep coming,
    // so the result path fills and the block must stall its input.
    task automatic test_result_backpressure();
        randomize_settings();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        holdoff_request = 250;
        repeat (40)
        begin
            if ($urandom_range(99) < 25)
                send_tick(PINS_W'($urandom));
            else
                send_query(opcode_t'($urandom_range(1, 3)), IDX_W'($urandom));
        end
        drain_results();
    endtask

    // ------------------------------------------------------------------
    // Main sequence.
    // ------------------------------------------------------------------
    initial
    begin
        rst_n                = 1'b0;
        item_if.valid        = 1'b0;
        item_if.opcode       = OP_TICK;
        item_if.pin_levels   = '0;
        item_if.button_index = '0;
        cfg_if.valid         = 1'b0;
        cfg_if.index         = CFG_SHORT_THR;
        cfg_if.data          = '0;
        reset_model();

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_press_sequences();
        test_button_count_limits();
        test_threshold_extremes();
        test_random_traffic(0, 0, 95);
        test_random_traffic(65, 0, 95);
        test_random_traffic(0, 65, 95);
        test_random_traffic(10, 10, 95);
        test_result_backpressure();

        if (expected_press.size() != 0)
            report_mismatch($sformatf("%0d queries never answered",
                                      expected_press.size()));
        if (mismatch_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

`default_nettype wire

// ----- filelist.f -----
rtl/core/slpc_pkg.sv
rtl/core/slpc_if.sv
rtl/core/slpc_lane.sv
rtl/core/short_long_press_classifier.sv
dv/short_long_press_classifier_tb.sv
